### hdl/pccs_pkg.sv
// Package with constants, types and the cut arithmetic constants of the polyline smoother.
package pccs_pkg;
  localparam int MaxInPoints = 16;
  localparam int MaxOutPoints = 64;
  localparam int Half = 64;
  localparam int AddrW = 7;
  localparam int CntW = 7;
  localparam logic [16:0] OneQ16 = 17'd65536;
  localparam logic [33:0] Div3Recip = 34'h2AAAAAAAB;
  localparam logic [0:0] RegRoundWeight = 1'b0;
  localparam logic [0:0] RegPassCount = 1'b1;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
    logic   trunc;
  } result_t;
endpackage

### hdl/pccs_if.sv
// Valid/ready channel interfaces for points, results and configuration writes.
interface pccs_point_if;
  import pccs_pkg::*;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic last_point;
  modport source(output valid, pos_x, pos_y, pos_z, last_point, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, last_point, output ready);
endinterface

interface pccs_result_if;
  logic valid;
  logic ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic last_out;
  logic truncated;
  modport source(output valid, out_x, out_y, out_z, last_out, truncated, input ready);
  modport sink(input valid, out_x, out_y, out_z, last_out, truncated, output ready);
endinterface

interface pccs_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [16:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### hdl/pccs_cut.sv
// Three-stage cut unit: scale the difference, round and shift, then divide by three.
module pccs_cut (
  input  logic                 clk,
  input  logic signed [31:0]   here,
  input  logic signed [31:0]   nb,
  input  logic [16:0]          w,
  output logic signed [31:0]   res
);
  import pccs_pkg::*;
  logic signed [32:0] diff;
  logic signed [50:0] prod;
  logic signed [31:0] here_d1, here_d2, here_d3;
  logic [50:0] mag;
  logic [32:0] scaled;
  logic [66:0] recip_prod;
  logic [31:0] quo;
  logic neg2, neg3;

  assign diff = 33'(nb) - 33'(here);
  assign mag = prod[50] ? 51'(-prod) : 51'(prod);
  // Division by 196608 is a shift by 16 followed by a reciprocal multiply for three.
  assign recip_prod = 67'(scaled) * 67'(Div3Recip);

  always_ff @(posedge clk) begin
    prod <= 51'(diff) * 51'($signed({1'b0, w}));
    here_d1 <= here;
    neg2 <= prod[50];
    scaled <= 33'((mag + 51'd98304) >> 16);
    here_d2 <= here_d1;
    neg3 <= neg2;
    quo <= recip_prod[66:35];
    here_d3 <= here_d2;
  end

  assign res = neg3 ? (here_d3 - $signed(quo)) : (here_d3 + $signed(quo));
endmodule

### hdl/polyline_corner_cut_smoother_core.sv
// Top level of the polyline corner-cut smoother with a ping-pong point memory.
//  channel | dir | transfer when
//  pts     | in  | pts.valid && pts.ready
//  res     | out | res.valid && res.ready
//  cfg     | in  | cfg.valid && cfg.ready
// Points load in one cycle each while the block is idle. Each point a pass produces needs
// two reads of the single read port, three cut stages and one write; each pass also goes
// through S_PASS. Each point emits via S_ERD, S_ELD and S_EMIT, which waits out stalls.
// Reset is synchronous; the memory needs none.
// A stalled result holds the emitter; no new point is taken until a run ends.
module polyline_corner_cut_smoother_core (
  input logic clk,
  input logic rst,
  pccs_point_if.sink pts,
  pccs_result_if.source res,
  pccs_cfg_if.sink cfg
);
  import pccs_pkg::*;

  typedef enum logic [8:0] {
    S_LOAD = 9'b000000001,
    S_PASS = 9'b000000010,
    S_RDH  = 9'b000000100,
    S_RDN  = 9'b000001000,
    S_CUT  = 9'b000010000,
    S_WR   = 9'b000100000,
    S_ERD  = 9'b001000000,
    S_ELD  = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_t;

  state_t state;
  point_t mem [2*Half];
  point_t rdata;
  point_t p_here;
  point_t cut_res;
  logic [AddrW-1:0] raddr;
  logic [AddrW-1:0] waddr;
  point_t wdata;
  logic mem_we;
  logic [16:0] round_weight;
  logic [3:0] pass_count;
  logic [3:0] pass_idx;
  logic [CntW-1:0] point_count, n, k, idx;
  logic [CntW-1:0] half_k, here_idx, nb_idx;
  logic overflow_seen, trunc, src_hi, load_ok;
  logic [1:0] cut_wait;
  logic [16:0] w;
  logic [CntW:0] m;

  assign w = (round_weight > OneQ16) ? OneQ16 : round_weight;
  assign m = (n < 7'd2) ? 8'd2 : 8'({1'b0, n, 1'b0} - 9'd2);
  assign load_ok = point_count < 7'(MaxInPoints);
  assign half_k = (k + 7'd1) >> 1;
  assign pts.ready = (state == S_LOAD);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  pccs_cut ux (.clk, .here(p_here.x), .nb(rdata.x), .w, .res(cut_res.x));
  pccs_cut uy (.clk, .here(p_here.y), .nb(rdata.y), .w, .res(cut_res.y));
  pccs_cut uz (.clk, .here(p_here.z), .nb(rdata.z), .w, .res(cut_res.z));

  // The end points are copied by cutting a point toward itself.
  always_comb begin
    priority if (k == '0) begin
      here_idx = '0;
      nb_idx = '0;
    end else if (k == 7'(m - 8'd1)) begin
      here_idx = n - 7'd1;
      nb_idx = n - 7'd1;
    end else begin
      here_idx = half_k;
      nb_idx = k[0] ? half_k - 7'd1 : half_k + 7'd1;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    waddr = {~src_hi, 6'(k)};
    wdata = cut_res;
    raddr = {src_hi, 6'(idx)};
    unique case (state)
      S_LOAD: begin
        mem_we = pts.valid && load_ok;
        waddr = {1'b0, 6'(point_count)};
        wdata = '{pts.pos_x, pts.pos_y, pts.pos_z};
      end
      S_RDH: raddr = {src_hi, 6'(here_idx)};
      S_RDN: raddr = {src_hi, 6'(nb_idx)};
      S_WR: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      round_weight <= OneQ16;
      pass_count <= 4'd3;
      point_count <= '0;
      overflow_seen <= 1'b0;
      res.valid <= 1'b0;
      src_hi <= 1'b0;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == RegRoundWeight) round_weight <= cfg.data;
        else if (cfg.index == RegPassCount) pass_count <= cfg.data[3:0];
      end
      unique case (state)
        S_LOAD: if (pts.valid) begin
          if (load_ok) point_count <= point_count + 7'd1;
          else overflow_seen <= 1'b1;
          if (pts.last_point) begin
            n <= load_ok ? point_count + 7'd1 : point_count;
            trunc <= overflow_seen || !load_ok;
            pass_idx <= '0;
            src_hi <= 1'b0;
            state <= S_PASS;
          end
        end
        S_PASS: begin
          k <= '0;
          idx <= '0;
          if (pass_idx == pass_count) begin
            state <= S_ERD;
          end else if (m > 8'(MaxOutPoints)) begin
            trunc <= 1'b1;
            state <= S_ERD;
          end else begin
            state <= S_RDH;
          end
        end
        S_RDH: state <= S_RDN;
        S_RDN: begin
          p_here <= rdata;
          cut_wait <= '0;
          state <= S_CUT;
        end
        S_CUT: begin
          cut_wait <= cut_wait + 2'd1;
          if (cut_wait == 2'd2) state <= S_WR;
        end
        S_WR: begin
          if (k == 7'(m - 8'd1)) begin
            n <= 7'(m);
            src_hi <= ~src_hi;
            pass_idx <= pass_idx + 4'd1;
            state <= S_PASS;
          end else begin
            k <= k + 7'd1;
            state <= S_RDH;
          end
        end
        S_ERD: state <= S_ELD;
        S_ELD: begin
          res.out_x <= rdata.x;
          res.out_y <= rdata.y;
          res.out_z <= rdata.z;
          res.last_out <= (idx == n - 7'd1);
          res.truncated <= trunc;
          res.valid <= 1'b1;
          state <= S_EMIT;
        end
        S_EMIT: if (res.ready) begin
          res.valid <= 1'b0;
          if (res.last_out) begin
            point_count <= '0; overflow_seen <= 1'b0; state <= S_LOAD;
          end else begin
            idx <= idx + 7'd1; state <= S_ERD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> res.valid) else $error("emit without valid");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> (res.valid && $stable(res.out_x) && $stable(res.out_y)
      && $stable(res.out_z) && $stable(res.last_out))) else $error("result changed in stall");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> !pts.ready) else $error("ready while busy");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= 7'(MaxInPoints)) else $error("point count overflow");
endmodule

### dv/tb_pccs_if_note.sv
// Testbench-side helper package with the point record used for path prediction.
`timescale 1ns / 100ps
package tb_pccs_types;
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } tb_point_t;
endpackage

### dv/tb_top.sv
// Testbench for the polyline corner-cut smoother: directed and random paths checked against a predictor.
`timescale 1ns / 100ps
module tb_top;
  import pccs_pkg::*;
  import tb_pccs_types::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  pccs_point_if pts();
  pccs_result_if res();
  pccs_cfg_if cfg();

  polyline_corner_cut_smoother_core i_dut (
    .clk(clk), .rst(rst), .pts(pts.sink), .res(res.source), .cfg(cfg.sink)
  );

  logic [16:0] weight_reg;
  logic [3:0] passes_reg;
  tb_point_t path_pts[$];
  logic path_overflow;
  result_t smoothed_q[$];
  int errors = 0;
  int points_sent = 0;
  int results_seen = 0;
  int paths_sent = 0;
  int res_gap = 0;
  int unsigned cycle_count = 0;
  bit no_stall = 1'b0;

  initial begin
    pts.valid = 1'b0;
    pts.pos_x = '0;
    pts.pos_y = '0;
    pts.pos_z = '0;
    pts.last_point = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = RegRoundWeight;
    cfg.data = '0;
    res.ready = 1'b0;
  end

  function automatic logic signed [31:0] cut_coord(logic signed [31:0] here,
                                                   logic signed [31:0] nb,
                                                   longint w);
    longint prod;
    longint q;
    prod = (longint'(nb) - longint'(here)) * w;
    if (prod < 0) q = -((-prod + 98304) / 196608);
    else q = (prod + 98304) / 196608;
    return 32'(longint'(here) + q);
  endfunction

  task automatic predict_path();
    tb_point_t cur[$];
    tb_point_t nxt[$];
    tb_point_t p;
    result_t r;
    longint w;
    bit trunc;
    int m;
    cur = path_pts;
    w = (weight_reg > OneQ16) ? 65536 : longint'(weight_reg);
    trunc = path_overflow;
    for (int ps = 0; ps < int'(passes_reg); ps++) begin
      m = (cur.size() < 2) ? 2 : 2 * cur.size() - 2;
      if (m > MaxOutPoints) begin
        trunc = 1'b1;
        break;
      end
      nxt = {};
      nxt = {nxt, cur[0]};
      for (int i = 1; i < cur.size() - 1; i++) begin
        p.x = cut_coord(cur[i].x, cur[i-1].x, w);
        p.y = cut_coord(cur[i].y, cur[i-1].y, w);
        p.z = cut_coord(cur[i].z, cur[i-1].z, w);
        nxt = {nxt, p};
        p.x = cut_coord(cur[i].x, cur[i+1].x, w);
        p.y = cut_coord(cur[i].y, cur[i+1].y, w);
        p.z = cut_coord(cur[i].z, cur[i+1].z, w);
        nxt = {nxt, p};
      end
      nxt = {nxt, cur[cur.size()-1]};
      cur = nxt;
    end
    foreach (cur[i]) begin
      r.x = cur[i].x;
      r.y = cur[i].y;
      r.z = cur[i].z;
      r.last = (i == cur.size() - 1);
      r.trunc = trunc;
      smoothed_q = {smoothed_q, r};
    end
    path_pts = {};
    path_overflow = 1'b0;
  endtask

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, logic last);
    tb_point_t p;
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      pts.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pts.valid <= 1'b1;
    pts.pos_x <= x;
    pts.pos_y <= y;
    pts.pos_z <= z;
    pts.last_point <= last;
    do @(posedge clk); while (!pts.ready);
    points_sent++;
    p.x = x;
    p.y = y;
    p.z = z;
    if (path_pts.size() < MaxInPoints) path_pts = {path_pts, p};
    else path_overflow = 1'b1;
    if (last) begin
      predict_path();
      paths_sent++;
    end
  endtask

  task automatic wait_drained();
    pts.valid <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [16:0] val);
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == RegRoundWeight) weight_reg = val;
    else passes_reg = val[3:0];
  endtask

  function automatic logic signed [31:0] rand_coord(bit wide);
    logic signed [31:0] v;
    v = $urandom();
    if (!wide) v = $signed(v) >>> $urandom_range(4, 24);
    return v;
  endfunction

  task automatic send_path(int n, bit wide);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(wide), rand_coord(wide), rand_coord(wide), i == n - 1);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (res.valid && res.ready) begin
      res_gap = no_stall ? 0 : $urandom_range(0, 6);
      res.ready <= (res_gap == 0);
    end else if (res_gap > 0) begin
      res_gap--;
      res.ready <= (res_gap == 0);
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && res.valid && res.ready) begin
      results_seen++;
      if (smoothed_q.size() == 0) begin
        $error("unexpected result x=%0d", res.out_x);
        errors++;
      end else begin
        exp_r = smoothed_q.pop_front();
        if (res.out_x !== exp_r.x) begin
          $error("out_x expected %0d actual %0d", exp_r.x, res.out_x); errors++;
        end
        if (res.out_y !== exp_r.y) begin
          $error("out_y expected %0d actual %0d", exp_r.y, res.out_y); errors++;
        end
        if (res.out_z !== exp_r.z) begin
          $error("out_z expected %0d actual %0d", exp_r.z, res.out_z); errors++;
        end
        if (res.last_out !== exp_r.last) begin
          $error("last_out expected %0b actual %0b", exp_r.last, res.last_out); errors++;
        end
        if (res.truncated !== exp_r.trunc) begin
          $error("truncated expected %0b actual %0b", exp_r.trunc, res.truncated); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 2000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_defaults();
    send_point(32'sh7fffffff, 32'sh80000000, 32'sd0, 1'b0);
    send_point(32'sh80000000, 32'sh7fffffff, -32'sd1, 1'b0);
    send_point(32'sd256, -32'sd256, 32'sh7fffffff, 1'b1);
  endtask

  task automatic test_special_cases();
    write_reg(RegPassCount, 17'd0);
    send_point(32'sd5, -32'sd5, 32'sd7, 1'b0);
    send_point(-32'sd3, 32'sd9, 32'sd1, 1'b1);
    send_point(32'sd11, 32'sd12, 32'sd13, 1'b1);
    write_reg(RegPassCount, 17'd15);
    send_point(32'sd11, 32'sd12, 32'sd13, 1'b1);
    write_reg(RegRoundWeight, 17'd0);
    send_path(4, 1'b1);
    write_reg(RegRoundWeight, 17'h1ffff);
    write_reg(RegPassCount, 17'd2);
    send_path(18, 1'b1);
    send_path(16, 1'b1);
  endtask

  task automatic test_random();
    int n;
    while (points_sent < 160) begin
      no_stall = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(RegRoundWeight, ($urandom_range(0, 3) == 0) ?
                  17'($urandom_range(65536, 131071)) : 17'($urandom_range(0, 65536)));
        write_reg(RegPassCount, 17'($urandom_range(0, 15)));
      end
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 8);
      send_path(n, $urandom_range(0, 1));
    end
    no_stall = 1'b0;
  endtask

  initial begin
    weight_reg = OneQ16;
    passes_reg = 4'd3;
    path_overflow = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_special_cases();
    test_random();
    wait_drained();
    $display("Sent %0d points in %0d paths and checked %0d smoothed points.",
             points_sent, paths_sent, results_seen);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

### polyline_corner_cut_smoother_core.f
hdl/pccs_pkg.sv
hdl/pccs_if.sv
hdl/pccs_cut.sv
hdl/polyline_corner_cut_smoother_core.sv
dv/tb_pccs_if_note.sv
dv/tb_top.sv
